FILE: rtl/core/biquad_filter_peak_normalizer_unit_defines.svh
// Assertion macros shared by the biquad peak normalizer checker.
`ifndef BIQUAD_FILTER_PEAK_NORMALIZER_UNIT_DEFINES_SVH
`define BIQUAD_FILTER_PEAK_NORMALIZER_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define BQPN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// Checked at every edge, reset included.
`define BQPN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bqpn_pkg.sv
// Shared constants, codes and control types of the biquad peak normalizer.
package bqpn_pkg;

  localparam int STORE_DEPTH    = 65536;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int CNT_W          = ADDR_W + 1;
  localparam int COEF_W         = 18;
  localparam int COEF_FRAC_BITS = 14;
  localparam int SAMPLE_W       = 16;
  localparam int VAL_W          = 48;
  localparam int OPD_W          = 17;
  localparam int PROD_W         = COEF_W + OPD_W;
  localparam int SUM_W          = 72;
  localparam int SCALE_SH       = 15;
  localparam int NUM_W          = VAL_W + SCALE_SH;
  localparam int Q_W            = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int STEP_W         = 4;

  localparam logic signed [SAMPLE_W-1:0] PCM_FULL_SCALE = 16'sd32767;

  localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_PULL = 1'b1;

  localparam logic [STEP_W-1:0] STEP_B0   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_B1   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_B2   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_A1_L = 4'd3;
  localparam logic [STEP_W-1:0] STEP_A1_M = 4'd4;
  localparam logic [STEP_W-1:0] STEP_A1_H = 4'd5;
  localparam logic [STEP_W-1:0] STEP_A2_L = 4'd6;
  localparam logic [STEP_W-1:0] STEP_A2_M = 4'd7;
  localparam logic [STEP_W-1:0] STEP_A2_H = 4'd8;
  localparam logic [STEP_W-1:0] DIV_FIRST = 4'd15;

  typedef struct packed {
    logic                push_start;
    logic                set_drop;
    logic                mul_en;
    logic [STEP_W-1:0]   step;
    logic                sat;
    logic                commit;
    logic                pull_start;
    logic                rd_issue;
    logic                div_load;
    logic                num_load;
    logic                div_step;
    logic                out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic has_data;
    logic out_busy;
  } stat_t;

endpackage

FILE: rtl/core/biquad_filter_peak_normalizer_unit.sv
// Top level of the biquad filter with peak normalizer.
//
//   channel | direction | tdata                 | tuser              | tlast
//   in_     | slave     | sample_in[15:0]       | opcode (1 = pull)  | -
//   out_    | master    | sample_out[15:0]      | overflowed         | last
//   cfg_    | write     | cfg_data[17:0] coef   | cfg_index 0..4     | -
//
// A push runs 9 passes of the shared 18x17 multiplier-accumulator plus
// saturation and the store write. A pull that yields an item runs the
// 16-step restoring divider, plus any wait for out_tready. A pull with
// nothing left yields no item. rst_n is synchronous, active low;
// the sample store is not cleared. One item is worked on at a time; a finished
// item in the output register does not hold off the next input.
module biquad_filter_peak_normalizer_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bqpn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bqpn_pkg::COEF_W-1:0]           cfg_data,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [bqpn_pkg::SAMPLE_W-1:0]         in_tdata,  // [15:0] sample_in
  input  logic                                  in_tuser,  // [0] opcode
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [bqpn_pkg::Q_W-1:0]              out_tdata, // [15:0] sample_out
  output logic                                  out_tlast,
  output logic                                  out_tuser  // [0] overflowed
);

  bqpn_pkg::cmd_t  cmd;
  bqpn_pkg::stat_t stat;

  bqpn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  bqpn_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (in_tdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: rtl/core/bqpn_ctrl.sv
// Sequencer that steps the filter MAC, the store and the divider for each item.
module bqpn_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic                 in_tuser,
  input  bqpn_pkg::stat_t      stat,
  output bqpn_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_FULL, S_MAC, S_MACW, S_SAT, S_UPD,
    S_PCHK, S_DLD, S_NUM, S_DIV, S_OUT
  } state_t;

  state_t                      state_r, state_nxt;
  logic [bqpn_pkg::STEP_W-1:0] cnt_r, cnt_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == bqpn_pkg::OP_PUSH) begin
            cmd.push_start = 1'b1;
            state_nxt      = S_FULL;
          end else begin
            cmd.pull_start = 1'b1;
            state_nxt      = S_PCHK;
          end
        end
      end
      S_FULL: begin
        if (stat.full) begin
          cmd.set_drop = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cnt_nxt   = bqpn_pkg::STEP_B0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        cmd.mul_en = 1'b1;
        cmd.step   = cnt_r;
        if (cnt_r == bqpn_pkg::STEP_A2_H) begin
          state_nxt = S_MACW;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // The last product lands in the accumulator here.
      S_MACW: state_nxt = S_SAT;
      S_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_PCHK: begin
        if (stat.has_data) begin
          cmd.rd_issue = 1'b1;
          state_nxt    = S_DLD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DLD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_NUM;
      end
      S_NUM: begin
        cmd.num_load = 1'b1;
        cnt_nxt      = bqpn_pkg::DIV_FIRST;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/bqpn_dp.sv
// Datapath: coefficients, filter history, shared MAC, sample store and divider.
module bqpn_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [bqpn_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bqpn_pkg::COEF_W-1:0]           cfg_data,
  input  logic signed [bqpn_pkg::SAMPLE_W-1:0]  sample_in,
  input  bqpn_pkg::cmd_t                        cmd,
  output bqpn_pkg::stat_t                       stat,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic [bqpn_pkg::Q_W-1:0]              out_tdata,
  output logic                                  out_tlast,
  output logic                                  out_tuser
);

  localparam int VW  = bqpn_pkg::VAL_W;
  localparam int SW  = bqpn_pkg::SUM_W;
  localparam int PW  = bqpn_pkg::PROD_W;
  localparam int NW  = bqpn_pkg::NUM_W;
  localparam int QW  = bqpn_pkg::Q_W;
  localparam int CW  = bqpn_pkg::CNT_W;
  localparam int FB  = bqpn_pkg::COEF_FRAC_BITS;
  localparam int SHW = SW - FB;

  logic signed [bqpn_pkg::COEF_W-1:0]   b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [bqpn_pkg::SAMPLE_W-1:0] x_r, x1_r, x2_r;
  logic signed [VW-1:0]                 y1_r, y2_r, y_r, peak_r, rdata_r;
  logic [CW-1:0]                        cnt_r, rd_idx_r;
  logic                                 drop_r, reading_r, last_r;

  logic signed [bqpn_pkg::COEF_W-1:0]   mc;
  logic signed [bqpn_pkg::OPD_W-1:0]    mo;
  logic                                 msub;
  logic [1:0]                           msh;
  logic signed [PW-1:0]                 prod_r;
  logic                                 psub_r, pvld_r;
  logic [1:0]                           psh_r;
  logic signed [SW-1:0]                 acc_r, pext, pshf;

  logic signed [SHW-1:0]                shd;
  logic [SHW-VW:0]                      shd_hi;
  logic signed [VW-1:0]                 ysat;
  logic [VW-1:0]                        ymag, pmag, vmag;

  logic [VW-1:0]                        vmag_r;
  logic                                 vneg_r, pzero_r;
  logic [NW-1:0]                        rem_r, dvs_r;
  logic [QW-1:0]                        q_r;

  logic signed [VW-1:0]                 store [bqpn_pkg::STORE_DEPTH];

  // Operand selection for the shared 18x17 multiplier; 48-bit outputs go in
  // three 16-bit slices, the top slice signed.
  always_comb begin
    mc   = '0;
    mo   = '0;
    msub = 1'b0;
    msh  = 2'd0;
    case (cmd.step)
      bqpn_pkg::STEP_B0: begin mc = b0_r; mo = {x_r[15], x_r}; end
      bqpn_pkg::STEP_B1: begin mc = b1_r; mo = {x1_r[15], x1_r}; end
      bqpn_pkg::STEP_B2: begin mc = b2_r; mo = {x2_r[15], x2_r}; end
      bqpn_pkg::STEP_A1_L: begin
        mc = a1_r; mo = {1'b0, y1_r[15:0]}; msub = 1'b1;
      end
      bqpn_pkg::STEP_A1_M: begin
        mc = a1_r; mo = {1'b0, y1_r[31:16]}; msub = 1'b1; msh = 2'd1;
      end
      bqpn_pkg::STEP_A1_H: begin
        mc = a1_r; mo = {y1_r[47], y1_r[47:32]}; msub = 1'b1; msh = 2'd2;
      end
      bqpn_pkg::STEP_A2_L: begin
        mc = a2_r; mo = {1'b0, y2_r[15:0]}; msub = 1'b1;
      end
      bqpn_pkg::STEP_A2_M: begin
        mc = a2_r; mo = {1'b0, y2_r[31:16]}; msub = 1'b1; msh = 2'd1;
      end
      bqpn_pkg::STEP_A2_H: begin
        mc = a2_r; mo = {y2_r[47], y2_r[47:32]}; msub = 1'b1; msh = 2'd2;
      end
      default: begin
        mc = '0;
      end
    endcase
  end

  assign pext = {{(SW-PW){prod_r[PW-1]}}, prod_r};
  always_comb begin
    case (psh_r)
      2'd1:    pshf = pext <<< 16;
      2'd2:    pshf = pext <<< 32;
      default: pshf = pext;
    endcase
  end

  // Drop the fraction bits (floor) and clamp to the signed 48-bit range.
  assign shd    = acc_r[SW-1:FB];
  assign shd_hi = shd[SHW-1:VW-1];
  always_comb begin
    if ((&shd_hi) || !(|shd_hi)) begin
      ysat = shd[VW-1:0];
    end else if (shd[SHW-1]) begin
      ysat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      ysat = {1'b0, {(VW-1){1'b1}}};
    end
  end

  assign ymag = y_r[VW-1]     ? VW'(-y_r)     : VW'(y_r);
  assign pmag = peak_r[VW-1]  ? VW'(-peak_r)  : VW'(peak_r);
  assign vmag = rdata_r[VW-1] ? VW'(-rdata_r) : VW'(rdata_r);

  assign stat.full     = (cnt_r == CW'(bqpn_pkg::STORE_DEPTH));
  assign stat.has_data = (rd_idx_r < cnt_r);
  assign stat.out_busy = out_tvalid & ~out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= bqpn_pkg::COEF_W'(1 << FB);
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bqpn_pkg::REG_B0: b0_r <= cfg_data;
        bqpn_pkg::REG_B1: b1_r <= cfg_data;
        bqpn_pkg::REG_B2: b2_r <= cfg_data;
        bqpn_pkg::REG_A1: a1_r <= cfg_data;
        bqpn_pkg::REG_A2: a2_r <= cfg_data;
        default: b0_r <= b0_r;
      endcase
    end
  end

  // Block state; a push after readout has begun starts a new block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r      <= '0;
      x2_r      <= '0;
      y1_r      <= '0;
      y2_r      <= '0;
      cnt_r     <= '0;
      rd_idx_r  <= '0;
      peak_r    <= '0;
      drop_r    <= 1'b0;
      reading_r <= 1'b0;
    end else begin
      if (cmd.push_start && reading_r) begin
        x1_r      <= '0;
        x2_r      <= '0;
        y1_r      <= '0;
        y2_r      <= '0;
        cnt_r     <= '0;
        rd_idx_r  <= '0;
        peak_r    <= '0;
        drop_r    <= 1'b0;
        reading_r <= 1'b0;
      end
      if (cmd.set_drop) begin
        drop_r <= 1'b1;
      end
      if (cmd.commit) begin
        x2_r  <= x1_r;
        x1_r  <= x_r;
        y2_r  <= y1_r;
        y1_r  <= y_r;
        cnt_r <= cnt_r + 1'b1;
        if (ymag > pmag) begin
          peak_r <= y_r;
        end
      end
      if (cmd.pull_start) begin
        reading_r <= 1'b1;
      end
      if (cmd.rd_issue) begin
        rd_idx_r <= rd_idx_r + 1'b1;
      end
    end
  end

  // Multiply stage, then accumulate stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_start) begin
      x_r   <= sample_in;
      acc_r <= '0;
    end else if (pvld_r) begin
      acc_r <= psub_r ? acc_r - pshf : acc_r + pshf;
    end
    prod_r <= mc * mo;
    psub_r <= msub;
    psh_r  <= msh;
    if (cmd.sat) begin
      y_r <= ysat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      store[cnt_r[bqpn_pkg::ADDR_W-1:0]] <= y_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rdata_r <= store[rd_idx_r[bqpn_pkg::ADDR_W-1:0]];
      last_r  <= (CW'(rd_idx_r + 1'b1) == cnt_r);
    end
  end

  // Restoring divider on magnitudes: |v| <= |peak|, so the quotient fits
  // in 16 bits and one bit is settled per cycle.
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      vmag_r  <= vmag;
      vneg_r  <= rdata_r[VW-1] ^ peak_r[VW-1];
      pzero_r <= (peak_r == '0);
      dvs_r   <= {pmag, {bqpn_pkg::SCALE_SH{1'b0}}};
    end
    if (cmd.num_load) begin
      rem_r <= {vmag_r, {bqpn_pkg::SCALE_SH{1'b0}}} - NW'(vmag_r);
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (rem_r >= dvs_r) begin
        rem_r <= rem_r - dvs_r;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      dvs_r <= dvs_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tdata <= pzero_r ? '0 : (vneg_r ? QW'(-q_r) : q_r);
      out_tlast <= last_r;
      out_tuser <= drop_r;
    end
  end

endmodule

FILE: rtl/core/bqpn_chk.sv
// Port-level checker for the biquad peak normalizer, bound to the top level.
`include "biquad_filter_peak_normalizer_unit_defines.svh"

module bqpn_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [bqpn_pkg::Q_W-1:0]      out_tdata,
  input logic                          out_tlast,
  input logic                          out_tuser
);

  `BQPN_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "out item dropped while stalled")
  `BQPN_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "out item changed while stalled")
  `BQPN_ASSERT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "input taken in back-to-back cycles")
  `BQPN_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_tvalid, "out valid right after reset")

endmodule

bind biquad_filter_peak_normalizer_unit bqpn_chk u_chk (.*);

FILE: sim/tb_top.sv
// Self-checking testbench for the biquad filter with peak normalizer.
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
    logic               ovf;
  } norm_t;

  typedef struct {
    logic               op;
    logic [15:0]        sample;
    bit                 pinned;
    logic signed [15:0] e_sample;
    logic               e_last;
    logic               e_ovf;
  } row_t;

  localparam logic signed [79:0] SAT_HI = (80'sd1 <<< 47) - 80'sd1;
  localparam logic signed [79:0] SAT_LO = -(80'sd1 <<< 47);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  biquad_filter_peak_normalizer_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Filter model state.
  logic signed [17:0] c_b0 = 18'sd16384, c_b1 = '0, c_b2 = '0, c_a1 = '0, c_a2 = '0;
  logic signed [15:0] x_d1, x_d2;
  logic signed [47:0] y_d1, y_d2, peak;
  logic signed [47:0] filt_store [bqpn_pkg::STORE_DEPTH];
  int unsigned        n_stored, rd_pos;
  bit                 dropped, reading;
  norm_t              pending_norm[$];
  int                 errors = 0;

  // Pinned expectation for the directed row being offered.
  bit    pin_valid = 0;
  norm_t pin_val;
  bit    quiet = 0;
  bit    hold_req = 0;

  function automatic logic [48:0] magnitude(logic signed [47:0] v);
    return v < 0 ? 49'(-(50'(v))) : 49'(v);
  endfunction

  function automatic void clear_block();
    x_d1 = '0; x_d2 = '0; y_d1 = '0; y_d2 = '0; peak = '0;
    n_stored = 0; rd_pos = 0; dropped = 0; reading = 0;
  endfunction

  // Updates the model for one accepted item and queues its result, if any.
  function automatic void filter_predict(logic op, logic [15:0] data);
    logic signed [79:0] acc;
    logic signed [79:0] sh;
    logic signed [47:0] y;
    longint             q;
    norm_t              r;
    if (op == bqpn_pkg::OP_PUSH) begin
      if (reading) clear_block();
      if (n_stored >= bqpn_pkg::STORE_DEPTH) begin
        dropped = 1;
        return;
      end
      acc = 80'(c_b0) * 80'($signed(data)) + 80'(c_b1) * 80'(x_d1) + 80'(c_b2) * 80'(x_d2)
          - 80'(c_a1) * 80'(y_d1) - 80'(c_a2) * 80'(y_d2);
      sh = acc >>> bqpn_pkg::COEF_FRAC_BITS;
      if (sh > SAT_HI) y = SAT_HI[47:0];
      else if (sh < SAT_LO) y = SAT_LO[47:0];
      else y = sh[47:0];
      x_d2 = x_d1; x_d1 = $signed(data);
      y_d2 = y_d1; y_d1 = y;
      filt_store[n_stored] = y;
      n_stored++;
      if (magnitude(y) > magnitude(peak)) peak = y;
      return;
    end
    reading = 1;
    if (rd_pos >= n_stored) return;
    q = 0;
    if (peak != 0) begin
      q = (longint'(filt_store[rd_pos]) * longint'(bqpn_pkg::PCM_FULL_SCALE)) / longint'(peak);
    end
    rd_pos++;
    r.sample = q[15:0];
    r.last = (rd_pos == n_stored);
    r.ovf = dropped;
    pending_norm.push_back(pin_valid ? pin_val : r);
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) filter_predict(in_tuser, in_tdata);
  end

  always @(posedge clk) begin
    norm_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_norm.size() == 0) begin
        $error("unexpected result sample_out=%0d", $signed(out_tdata));
        errors++;
      end else begin
        e = pending_norm.pop_front();
        if (out_tdata !== e.sample) begin
          $error("sample_out: expected %0d, got %0d", e.sample, $signed(out_tdata));
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, out_tlast);
          errors++;
        end
        if (out_tuser !== e.ovf) begin
          $error("overflowed: expected %0b, got %0b", e.ovf, out_tuser);
          errors++;
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int g;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      g = pick_gap();
      out_tready <= (g == 0);
      if (g > 1) repeat (g - 1) @(negedge clk);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(logic op, logic [15:0] data);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_norm.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_coef(logic [2:0] idx, logic signed [17:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bqpn_pkg::REG_B0: c_b0 = val;
      bqpn_pkg::REG_B1: c_b1 = val;
      bqpn_pkg::REG_B2: c_b2 = val;
      bqpn_pkg::REG_A1: c_a1 = val;
      bqpn_pkg::REG_A2: c_a2 = val;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7fff;
    if (r == 1) return 16'h8000;
    if (r == 2) return 16'($urandom_range(0, 15)) - 16'd8;
    return 16'($urandom);
  endfunction

  function automatic logic signed [17:0] rand_coef();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 18'($urandom);
    return 18'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  row_t dir_rows[$] = '{
    '{bqpn_pkg::OP_PUSH, 16'h7fff, 0, 0, 0, 0},
    '{bqpn_pkg::OP_PUSH, 16'h8000, 0, 0, 0, 0},
    '{bqpn_pkg::OP_PUSH, 16'h0000, 0, 0, 0, 0},
    '{bqpn_pkg::OP_PULL, 16'h0000, 1, -16'sd32766, 0, 0},
    '{bqpn_pkg::OP_PULL, 16'hffff, 1, 16'sd32767, 0, 0},
    '{bqpn_pkg::OP_PULL, 16'h0000, 1, 16'sd0, 1, 0},
    '{bqpn_pkg::OP_PULL, 16'h1234, 0, 0, 0, 0},
    '{bqpn_pkg::OP_PUSH, 16'h0000, 0, 0, 0, 0},
    '{bqpn_pkg::OP_PULL, 16'h0000, 1, 16'sd0, 1, 0},
    '{bqpn_pkg::OP_PUSH, 16'd100, 0, 0, 0, 0},
    '{bqpn_pkg::OP_PUSH, -16'sd100, 0, 0, 0, 0},
    '{bqpn_pkg::OP_PUSH, 16'd5, 0, 0, 0, 0},
    '{bqpn_pkg::OP_PULL, 16'h0000, 1, 16'sd32767, 0, 0},
    '{bqpn_pkg::OP_PULL, 16'h0000, 1, -16'sd32767, 0, 0},
    '{bqpn_pkg::OP_PULL, 16'h0000, 1, 16'sd1638, 1, 0},
    '{bqpn_pkg::OP_PUSH, -16'sd3, 0, 0, 0, 0},
    '{bqpn_pkg::OP_PUSH, 16'd1, 0, 0, 0, 0},
    '{bqpn_pkg::OP_PULL, 16'h0000, 1, 16'sd32767, 0, 0},
    '{bqpn_pkg::OP_PULL, 16'h0000, 1, -16'sd10922, 1, 0},
    '{bqpn_pkg::OP_PULL, 16'h0000, 0, 0, 0, 0}
  };

  initial begin
    int n, k;
    clear_block();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      pin_valid = dir_rows[i].pinned;
      pin_val = '{dir_rows[i].e_sample, dir_rows[i].e_last, dir_rows[i].e_ovf};
      send_item(dir_rows[i].op, dir_rows[i].sample);
    end
    pin_valid = 0;

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      if (ph == 0) begin
        write_coef(bqpn_pkg::REG_B0, 18'sh1ffff); write_coef(bqpn_pkg::REG_B1, -18'sd131072);
        write_coef(bqpn_pkg::REG_B2, 18'sh1ffff); write_coef(bqpn_pkg::REG_A1, -18'sd131072);
        write_coef(bqpn_pkg::REG_A2, 18'sh1ffff);
      end else if (ph == 1) begin
        write_coef(bqpn_pkg::REG_B0, -18'sd131072); write_coef(bqpn_pkg::REG_B1, 18'sh1ffff);
        write_coef(bqpn_pkg::REG_B2, -18'sd131072); write_coef(bqpn_pkg::REG_A1, 18'sh1ffff);
        write_coef(bqpn_pkg::REG_A2, -18'sd131072);
      end else begin
        write_coef(bqpn_pkg::REG_B0, rand_coef()); write_coef(bqpn_pkg::REG_B1, rand_coef());
        write_coef(bqpn_pkg::REG_B2, rand_coef()); write_coef(bqpn_pkg::REG_A1, rand_coef());
        write_coef(bqpn_pkg::REG_A2, rand_coef());
      end
      quiet = (ph == 4);
      if (ph == 2) hold_req = 1;
      n = 0;
      while (n < 55) begin
        if ($urandom_range(0, 9) < 8) begin
          k = $urandom_range(1, 10);
          repeat (k) send_item(bqpn_pkg::OP_PUSH, rand_sample());
          repeat (k + $urandom_range(0, 1)) send_item(bqpn_pkg::OP_PULL, 16'($urandom));
          n += 2 * k;
        end else begin
          repeat ($urandom_range(1, 4)) begin
            send_item(1'($urandom), rand_sample());
            n++;
          end
        end
      end
    end
    quiet = 0;

    drain();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
